// ===== hdl/trilinear_sample_mirror_boundary_top_defines.svh =====
// Assertion macros shared by the checker of the trilinear sampler.
// No dependencies; include by bare file name.
`ifndef TRILINEAR_SAMPLE_MIRROR_BOUNDARY_TOP_DEFINES_SVH
`define TRILINEAR_SAMPLE_MIRROR_BOUNDARY_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TSMB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TSMB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tsmb_pkg.sv =====
// Shared types and constants of the trilinear sampler with mirror boundary.
// No dependencies; imported by every module of the block but tsmb_ram.
`default_nettype none

package tsmb_pkg;

   localparam int MAX_DIM     = 32;
   localparam int VOXEL_BITS  = 16;
   localparam int FRAC_BITS   = 8;
   localparam int NUM_AXES    = 3;

   localparam int DIM_W       = 6;
   localparam int IDX_W       = $clog2(MAX_DIM);
   localparam int P_W         = DIM_W;
   localparam int POS_W       = 24;
   localparam int INT_W       = POS_W - FRAC_BITS;
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int OUT_W       = 24;

   localparam int WGT_W       = FRAC_BITS + 1;
   localparam int WYZ_W       = 2 * FRAC_BITS + 1;
   localparam int W_W         = 3 * FRAC_BITS + 1;
   localparam int ACC_W       = VOXEL_BITS + 3 * FRAC_BITS + 1;
   localparam int OY_W        = 2 * IDX_W;
   localparam int DXY_W       = 2 * IDX_W + 1;

   localparam int MOD_STEP_BITS = 4;
   localparam int MOD_STEPS     = INT_W / MOD_STEP_BITS;
   localparam int NUM_CORNERS   = 8;
   localparam int CNT_W         = $clog2(NUM_CORNERS);

   localparam int ADDR_LSB    = 0;
   localparam int VALUE_LSB   = ADDR_LSB + ADDR_W;
   localparam int POS_X_LSB   = VALUE_LSB + VOXEL_BITS;
   localparam int REQ_FIELDS_W = POS_X_LSB + NUM_AXES * POS_W;
   localparam int REQ_TDATA_W = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_IDX_W   = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z = CSR_IDX_W'(2);

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_MAP,
      ST_OFFS,
      ST_READ,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic             load_sample;
      logic             write_voxel;
      logic             mod_step;
      logic             map;
      logic             offs;
      logic             read_en;
      logic [CNT_W-1:0] corner;
      logic             load_out;
   } cmd_type;

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      if (d == '0) begin
         r = DIM_W'(1);
      end else if (d > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/trilinear_sample_mirror_boundary_top.sv =====
// Top level of the trilinear sampler with mirror boundary.
// Depends on tsmb_pkg, tsmb_ctrl and tsmb_datapath.
//
// Usage: the csr_ channel writes the volume sizes (index 0 x, 1 y, 2 z); it is
// always ready. Requests on the req_ channel either store one voxel
// (req_tuser low) or ask for one sample (req_tuser high). Voxel writes
// stream at one per cycle while no sample is in progress. A sample gives one
// response on the rsp_ channel, and the next request is taken only once the
// sample has passed its result to the output register, so samples do not
// overlap; the sample time is set by the four-step remainder units and the
// eight reads on the RAM's single read port. The result sits in an output
// register, so a stalled receiver does not hold back voxel writes; a sample
// that finishes while an earlier response is still waiting holds until that
// response is taken. Reset sets all three sizes to 32 and empties the output
// register; the voxel contents are not cleared and must be written before
// they are sampled. Sizes may only change while no sample is in flight.
`default_nettype none

module trilinear_sample_mirror_boundary_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: voxel_address, voxel_value, pos_x, pos_y, pos_z, pad.
   input  wire logic [tsmb_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: kind.
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // Fields from bit 0: sample_value.
   output logic      [tsmb_pkg::OUT_W-1:0]       rsp_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tsmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tsmb_pkg::DIM_W-1:0]       csr_data
);
   import tsmb_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   tsmb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   tsmb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hdl/tsmb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsmb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tsmb_mod.sv =====
// Iterative remainder unit: reduces an unsigned index modulo the mirror period,
// a few dividend bits per step, most significant first. Depends on tsmb_pkg.
`default_nettype none

module tsmb_mod (
   input  wire logic                      clock,
   input  wire logic                      start,
   input  wire logic                      step,
   input  wire logic [tsmb_pkg::INT_W-1:0] dividend,
   input  wire logic [tsmb_pkg::P_W-1:0]   divisor,
   output logic      [tsmb_pkg::P_W-1:0]   rem
);
   import tsmb_pkg::*;

   logic [INT_W-1:0] dvd_ff, dvd_in;
   logic [P_W-1:0]   rem_ff, rem_in;
   logic [P_W:0]     r;

   always_comb begin
      r = {1'b0, rem_ff};
      for (int j = 0; j < MOD_STEP_BITS; j++) begin
         r = {r[P_W-1:0], dvd_ff[INT_W-1-j]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
         end
      end
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
      end else if (step) begin
         dvd_in = dvd_ff << MOD_STEP_BITS;
         rem_in = r[P_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign rem = rem_ff;

endmodule

`default_nettype wire

// ===== hdl/tsmb_datapath.sv =====
// Datapath of the trilinear sampler: dimension registers, index split, mirror
// mapping, address and weight generation, voxel RAM and accumulator.
// Depends on tsmb_pkg, tsmb_mod and tsmb_ram.
`default_nettype none

module tsmb_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire tsmb_pkg::cmd_type                cmd,
   input  wire logic [tsmb_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             csr_valid,
   input  wire logic [tsmb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [tsmb_pkg::DIM_W-1:0]       csr_data,
   output logic      [tsmb_pkg::OUT_W-1:0]       rsp_tdata
);
   import tsmb_pkg::*;

   function automatic logic [IDX_W-1:0] mirror_fold(input logic [P_W-1:0] r,
                                                    input logic [P_W-1:0] d,
                                                    input logic [P_W-1:0] p);
      logic [P_W-1:0] t;
      t = p - r;
      if (d == P_W'(1)) begin
         return '0;
      end else if (r < d) begin
         return r[IDX_W-1:0];
      end else begin
         return t[IDX_W-1:0];
      end
   endfunction

   logic [DIM_W-1:0] dim_raw_ff [NUM_AXES];
   logic [DIM_W-1:0] dim_raw_in [NUM_AXES];

   logic [DIM_W-1:0]     dim_ff   [NUM_AXES];
   logic [DIM_W-1:0]     dim_in   [NUM_AXES];
   logic [DIM_W-1:0]     dim_m1   [NUM_AXES];
   logic [P_W-1:0]       p_ff     [NUM_AXES];
   logic [P_W-1:0]       p_in     [NUM_AXES];
   logic                 neg_ff   [NUM_AXES];
   logic                 neg_in   [NUM_AXES];
   logic [FRAC_BITS-1:0] frac_ff  [NUM_AXES];
   logic [FRAC_BITS-1:0] frac_in  [NUM_AXES];
   logic [POS_W-1:0]     pos_fld  [NUM_AXES];
   logic [INT_W-1:0]     idx_fld  [NUM_AXES];
   logic [INT_W-1:0]     abs_idx  [NUM_AXES];
   logic [P_W-1:0]       rem      [NUM_AXES];
   logic [P_W-1:0]       r1       [NUM_AXES];
   logic [IDX_W-1:0]     o_ff     [NUM_AXES][2];
   logic [IDX_W-1:0]     o_in     [NUM_AXES][2];
   logic [WGT_W-1:0]     wgt      [NUM_AXES][2];

   logic [2*DIM_W-1:0]   dxy_prod;
   logic [DXY_W-1:0]     dxy_ff, dxy_in;

   logic [IDX_W+DIM_W-1:0]   oy_prod  [2];
   logic [IDX_W+DXY_W-1:0]   oz_prod  [2];
   logic [OY_W-1:0]          oy_ff    [2];
   logic [OY_W-1:0]          oy_in    [2];
   logic [ADDR_W-1:0]        oz_ff    [2];
   logic [ADDR_W-1:0]        oz_in    [2];
   logic [2*WGT_W-1:0]       wyz_prod [2][2];
   logic [WYZ_W-1:0]         wyz_ff   [2][2];
   logic [WYZ_W-1:0]         wyz_in   [2][2];

   logic [ADDR_W-1:0]        rd_addr;
   logic [WYZ_W+WGT_W-1:0]   w_prod;
   logic [W_W-1:0]           w_ff, w_in;
   logic                     rd_valid_ff;
   logic [VOXEL_BITS-1:0]    rd_data;
   logic signed [VOXEL_BITS-1:0]   vox_s;
   logic signed [W_W:0]            w_s;
   logic signed [VOXEL_BITS+W_W:0] prod;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [OUT_W-1:0]         rsp_data_ff, rsp_data_in;

   // Configuration registers.
   always_comb begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         dim_raw_in[ax] = dim_raw_ff[ax];
      end
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DIM_X: dim_raw_in[0] = csr_data;
            CSR_DIM_Y: dim_raw_in[1] = csr_data;
            CSR_DIM_Z: dim_raw_in[2] = csr_data;
            default: ;
         endcase
      end
   end

   // Split of each coordinate into integer index and fraction.
   always_comb begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         pos_fld[ax] = req_tdata[POS_X_LSB + ax * POS_W +: POS_W];
         idx_fld[ax] = pos_fld[ax][POS_W-1:FRAC_BITS];
         neg_in[ax]  = idx_fld[ax][INT_W-1];
         abs_idx[ax] = neg_in[ax] ? (~idx_fld[ax] + INT_W'(1)) : idx_fld[ax];
         frac_in[ax] = pos_fld[ax][FRAC_BITS-1:0];
         dim_in[ax]  = eff_dim(dim_raw_ff[ax]);
         dim_m1[ax]  = dim_in[ax] - DIM_W'(1);
         p_in[ax]    = {dim_m1[ax][DIM_W-2:0], 1'b0};
      end
      dxy_prod = dim_in[0] * dim_in[1];
      dxy_in   = dxy_prod[DXY_W-1:0];
   end

   for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_mod
      tsmb_mod u_mod (
         .clock    (clock),
         .start    (cmd.load_sample),
         .step     (cmd.mod_step),
         .dividend (abs_idx[ax]),
         .divisor  (p_ff[ax]),
         .rem      (rem[ax])
      );
   end

   // Mirror mapping of both neighbors; the second one is one step from the first.
   always_comb begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         if (neg_ff[ax]) begin
            r1[ax] = (rem[ax] == '0) ? p_ff[ax] - P_W'(1) : rem[ax] - P_W'(1);
         end else begin
            r1[ax] = (rem[ax] + P_W'(1) == p_ff[ax]) ? '0 : rem[ax] + P_W'(1);
         end
         o_in[ax][0] = mirror_fold(rem[ax], dim_ff[ax], p_ff[ax]);
         o_in[ax][1] = mirror_fold(r1[ax], dim_ff[ax], p_ff[ax]);
      end
   end

   // Row and slice offsets, and the weights.
   always_comb begin
      for (int ax = 0; ax < NUM_AXES; ax++) begin
         wgt[ax][0] = WGT_ONE - {1'b0, frac_ff[ax]};
         wgt[ax][1] = {1'b0, frac_ff[ax]};
      end
      for (int k = 0; k < 2; k++) begin
         oy_prod[k] = o_ff[1][k] * dim_ff[0];
         oy_in[k]   = oy_prod[k][OY_W-1:0];
         oz_prod[k] = o_ff[2][k] * dxy_ff;
         oz_in[k]   = oz_prod[k][ADDR_W-1:0];
      end
      for (int a = 0; a < 2; a++) begin
         for (int b = 0; b < 2; b++) begin
            wyz_prod[a][b] = wgt[1][b] * wgt[2][a];
            wyz_in[a][b]   = wyz_prod[a][b][WYZ_W-1:0];
         end
      end
   end

   // Corner address, corner weight and accumulation.
   always_comb begin
      rd_addr = oz_ff[cmd.corner[2]] + ADDR_W'(oy_ff[cmd.corner[1]])
              + ADDR_W'(o_ff[0][cmd.corner[0]]);
      w_prod  = wyz_ff[cmd.corner[2]][cmd.corner[1]] * wgt[0][cmd.corner[0]];
      w_in    = w_prod[W_W-1:0];
      vox_s   = rd_data;
      w_s     = {1'b0, w_ff};
      prod    = vox_s * w_s;
      acc_in  = acc_ff;
      if (cmd.offs) begin
         acc_in = '0;
      end else if (rd_valid_ff) begin
         acc_in = acc_ff + prod[ACC_W-1:0];
      end
      rsp_data_in = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_data_in = acc_ff[2*FRAC_BITS +: OUT_W];
      end
   end

   tsmb_ram #(
      .WIDTH (VOXEL_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.write_voxel),
      .wr_addr (req_tdata[ADDR_LSB +: ADDR_W]),
      .wr_data (req_tdata[VALUE_LSB +: VOXEL_BITS]),
      .rd_en   (cmd.read_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ax = 0; ax < NUM_AXES; ax++) begin
            dim_raw_ff[ax] <= DIM_W'(MAX_DIM);
         end
         rd_valid_ff <= 1'b0;
      end else begin
         dim_raw_ff  <= dim_raw_in;
         rd_valid_ff <= cmd.read_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) begin
         dim_ff  <= dim_in;
         p_ff    <= p_in;
         neg_ff  <= neg_in;
         frac_ff <= frac_in;
         dxy_ff  <= dxy_in;
      end
      if (cmd.map) begin
         o_ff <= o_in;
      end
      if (cmd.offs) begin
         oy_ff  <= oy_in;
         oz_ff  <= oz_in;
         wyz_ff <= wyz_in;
      end
      if (cmd.read_en) begin
         w_ff <= w_in;
      end
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/tsmb_ctrl.sv =====
// Controller of the trilinear sampler: sequences one sample through modulo,
// mapping, offset, eight voxel reads and result hand-off. Depends on tsmb_pkg.
`default_nettype none

module tsmb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   input  wire logic              req_tuser,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output tsmb_pkg::cmd_type      cmd
);
   import tsmb_pkg::*;

   localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(MOD_STEPS - 1);
   localparam logic [CNT_W-1:0] READ_LAST = CNT_W'(NUM_CORNERS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == KIND_SAMPLE) begin
                  cmd.load_sample = 1'b1;
                  cnt_in          = '0;
                  state_in        = ST_MOD;
               end else begin
                  cmd.write_voxel = 1'b1;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (cnt_ff == MOD_LAST) begin
               cnt_in   = '0;
               state_in = ST_MAP;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_OFFS;
         end
         ST_OFFS: begin
            cmd.offs = 1'b1;
            cnt_in   = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
            cmd.corner  = cnt_ff;
            if (cnt_ff == READ_LAST) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

`default_nettype wire

// ===== hdl/tsmb_checker.sv =====
// Port-level checker of the trilinear sampler, bound to the top level.
// Depends on tsmb_pkg and the assertion macro header.
`default_nettype none
`include "trilinear_sample_mirror_boundary_top_defines.svh"

module tsmb_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       req_tuser,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [tsmb_pkg::OUT_W-1:0] rsp_tdata
);
   import tsmb_pkg::*;

   logic sample_acc;
   logic write_acc;

   assign sample_acc = req_tvalid && req_tready && (req_tuser == KIND_SAMPLE);
   assign write_acc  = req_tvalid && req_tready && (req_tuser == KIND_WRITE);

   `TSMB_ASSERT_NXT(a_rsp_valid_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "Response withdrawn while stalled.")
   `TSMB_ASSERT_NXT(a_rsp_data_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata), "Response data changed while stalled.")
   `TSMB_ASSERT_NXT(a_sample_busy, clock, reset, sample_acc, !req_tready, "Request taken while a sample is in progress.")
   `TSMB_ASSERT_NXT(a_write_ready, clock, reset, write_acc, req_tready, "Voxel write did not free the request channel.")

endmodule

bind trilinear_sample_mirror_boundary_top tsmb_checker u_tsmb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== verif/trilinear_sample_mirror_boundary_top_tb.sv =====
// Self-checking testbench for the trilinear sampler with mirror boundary.
// Depends on tsmb_pkg and trilinear_sample_mirror_boundary_top; predicts every
// sample from its own copy of the volume and the sizes and checks each response.
`timescale 1ns / 100ps

module trilinear_sample_mirror_boundary_top_tb;
   import tsmb_pkg::*;

   localparam int CLOCK_HALF = 4;
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS = 560;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   class sample_predictor;
      logic signed [VOXEL_BITS-1:0] voxel_mem [STORE_DEPTH];
      bit voxel_written [STORE_DEPTH];
      logic [DIM_W-1:0] size_reg [NUM_AXES];
      logic [OUT_W-1:0] expected_samples [$];
      int mismatch_count;

      function new();
         foreach (size_reg[a]) size_reg[a] = DIM_W'(MAX_DIM);
         mismatch_count = 0;
      endfunction

      task report(string what);
         mismatch_count++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [DIM_W-1:0] value);
         case (index)
            CSR_DIM_X: size_reg[0] = value;
            CSR_DIM_Y: size_reg[1] = value;
            CSR_DIM_Z: size_reg[2] = value;
            default: ;
         endcase
      endfunction

      function int active_size(logic [DIM_W-1:0] d);
         if (d == 0) return 1;
         if (d > MAX_DIM) return MAX_DIM;
         return int'(d);
      endfunction

      function int mirror(longint i, int dim);
         longint a;
         longint p;
         a = (i < 0) ? -i : i;
         if (dim <= 1) return 0;
         p = 2 * (dim - 1);
         a = a % p;
         return (a < dim) ? int'(a) : int'(p - a);
      endfunction

      function int corner_address(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                  logic [POS_W-1:0] pz, int c);
         logic signed [POS_W-1:0] coord [NUM_AXES];
         int dim [NUM_AXES];
         int idx [NUM_AXES];
         coord[0] = px;
         coord[1] = py;
         coord[2] = pz;
         for (int a = 0; a < NUM_AXES; a++) begin
            dim[a] = active_size(size_reg[a]);
            idx[a] = mirror((longint'(coord[a]) >>> FRAC_BITS) + ((c >> a) & 1), dim[a]);
         end
         return idx[0] + idx[1] * dim[0] + idx[2] * dim[0] * dim[1];
      endfunction

      function void note_request(logic kind, logic [REQ_TDATA_W-1:0] data);
         int dim [NUM_AXES];
         longint base [NUM_AXES];
         longint wgt [NUM_AXES][2];
         int offs [NUM_AXES][2];
         logic signed [POS_W-1:0] coord;
         longint acc;
         longint blended;
         if (kind == KIND_WRITE) begin
            voxel_mem[data[ADDR_LSB +: ADDR_W]] = data[VALUE_LSB +: VOXEL_BITS];
            voxel_written[data[ADDR_LSB +: ADDR_W]] = 1'b1;
            return;
         end
         for (int a = 0; a < NUM_AXES; a++) begin
            dim[a] = active_size(size_reg[a]);
            coord = data[POS_X_LSB + a * POS_W +: POS_W];
            base[a] = longint'(coord) >>> FRAC_BITS;
            wgt[a][1] = longint'(coord[FRAC_BITS-1:0]);
            wgt[a][0] = (longint'(1) << FRAC_BITS) - wgt[a][1];
         end
         for (int k = 0; k < 2; k++) begin
            offs[0][k] = mirror(base[0] + k, dim[0]);
            offs[1][k] = mirror(base[1] + k, dim[1]) * dim[0];
            offs[2][k] = mirror(base[2] + k, dim[2]) * dim[0] * dim[1];
         end
         acc = 0;
         for (int z = 0; z < 2; z++)
            for (int y = 0; y < 2; y++)
               for (int x = 0; x < 2; x++)
                  acc += longint'(voxel_mem[offs[2][z] + offs[1][y] + offs[0][x]])
                         * wgt[0][x] * wgt[1][y] * wgt[2][z];
         blended = acc >>> (2 * FRAC_BITS);
         if (blended > 64'sd8388607) blended = 64'sd8388607;
         if (blended < -64'sd8388608) blended = -64'sd8388608;
         expected_samples.push_back(blended[OUT_W-1:0]);
      endfunction

      task check_sample(logic [OUT_W-1:0] got);
         logic [OUT_W-1:0] want;
         if (expected_samples.size() == 0) begin
            report($sformatf("unexpected sample_value %h", got));
            return;
         end
         want = expected_samples.pop_front();
         if (got !== want) report($sformatf("sample_value %h, expected %h", got, want));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic req_tuser = KIND_WRITE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [OUT_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DIM_X;
   logic [DIM_W-1:0] csr_data = '0;

   int req_idle_pct = 10;
   int rsp_idle_pct = 46;
   sample_predictor pred = new();

   trilinear_sample_mirror_boundary_top uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("trilinear_sample_mirror_boundary_top verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) pred.check_sample(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_request(logic kind, logic [ADDR_W-1:0] addr,
                               logic [VOXEL_BITS-1:0] value, logic [POS_W-1:0] px,
                               logic [POS_W-1:0] py, logic [POS_W-1:0] pz);
      logic [REQ_TDATA_W-1:0] data;
      data = '0;
      data[ADDR_LSB +: ADDR_W] = addr;
      data[VALUE_LSB +: VOXEL_BITS] = value;
      data[POS_X_LSB +: POS_W] = px;
      data[POS_X_LSB + POS_W +: POS_W] = py;
      data[POS_X_LSB + 2 * POS_W +: POS_W] = pz;
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      pred.note_request(kind, data);
   endtask

   task automatic write_voxel(logic [ADDR_W-1:0] addr, logic [VOXEL_BITS-1:0] value);
      send_request(KIND_WRITE, addr, value, POS_W'($urandom), POS_W'($urandom),
                   POS_W'($urandom));
   endtask

   // A sample first loads those of its eight neighbors that were never written.
   task automatic fill_corners(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                               logic [POS_W-1:0] pz);
      int addr;
      for (int c = 0; c < NUM_CORNERS; c++) begin
         addr = pred.corner_address(px, py, pz, c);
         if (!pred.voxel_written[addr]) write_voxel(ADDR_W'(addr), VOXEL_BITS'($urandom));
      end
   endtask

   task automatic sample_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                            logic [POS_W-1:0] pz);
      fill_corners(px, py, pz);
      send_request(KIND_SAMPLE, ADDR_W'($urandom), VOXEL_BITS'($urandom), px, py, pz);
   endtask

   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pred.expected_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [DIM_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      pred.set_register(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_sizes(logic [DIM_W-1:0] x, logic [DIM_W-1:0] y, logic [DIM_W-1:0] z);
      drain_and_settle();
      write_csr(CSR_DIM_X, x);
      write_csr(CSR_DIM_Y, y);
      write_csr(CSR_DIM_Z, z);
   endtask

   function automatic logic [POS_W-1:0] q8(int whole, int frac);
      return POS_W'(whole * (1 << FRAC_BITS) + frac);
   endfunction

   function automatic logic [DIM_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) return DIM_W'($urandom_range(4, 1));
      if (roll < 95) return DIM_W'($urandom_range(8, 5));
      return '0;
   endfunction

   function automatic logic [POS_W-1:0] pick_position(int dim);
      int span;
      if ($urandom_range(9) < 2) return POS_W'($urandom);
      span = 3 * dim + 2;
      return q8(int'($urandom_range(2 * span)) - span, int'($urandom_range(255)));
   endfunction

   initial begin
      int dx;
      int dy;
      int dz;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_corners('0, '0, '0);
      send_request(KIND_SAMPLE, '1, '1, '0, '0, '0);
      send_request(KIND_WRITE, '0, 16'h8000, '1, '1, '1);
      send_request(KIND_WRITE, '1, 16'h7fff, '0, '0, '0);
      sample_at('0, '0, '0);
      sample_at(24'h7fffff, 24'h7fffff, 24'h7fffff);
      sample_at(24'h800000, 24'h800000, 24'h800000);
      sample_at(24'hffffff, 24'hffffff, 24'hffffff);
      sample_at(24'h0000ff, 24'h0000ff, 24'h0000ff);
      sample_at(q8(31, 128), q8(31, 0), q8(30, 200));
      sample_at(q8(62, 64), q8(-62, 64), q8(-31, 5));
      sample_at(q8(32, 0), q8(63, 255), q8(-1, 0));

      // Single-voxel volume: every neighbour is entry zero, so the blend hits
      // both ends of the voxel value range.
      set_sizes(DIM_W'(1), DIM_W'(1), DIM_W'(1));
      write_voxel('0, 16'h7fff);
      sample_at(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));
      write_voxel('0, 16'h8000);
      sample_at(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom));

      // A zero size acts as one, sizes above the store saturate.
      set_sizes(DIM_W'(0), DIM_W'(63), DIM_W'(33));
      write_csr(CSR_SPARE, DIM_W'($urandom));
      sample_at(q8(2, 17), q8(40, 99), q8(-33, 1));
      sample_at(q8(-5, 250), q8(31, 255), q8(62, 0));
      sample_at(24'h800000, 24'h7fffff, 24'h000100);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            req_idle_pct = 46;
            rsp_idle_pct = 10;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (n % 100 == 0) set_sizes(pick_size(), pick_size(), pick_size());
         dx = pred.active_size(pred.size_reg[0]);
         dy = pred.active_size(pred.size_reg[1]);
         dz = pred.active_size(pred.size_reg[2]);
         if ($urandom_range(1) == 1) begin
            sample_at(pick_position(dx), pick_position(dy), pick_position(dz));
         end else if ($urandom_range(9) < 6) begin
            write_voxel(ADDR_W'($urandom_range(dx * dy * dz - 1)), VOXEL_BITS'($urandom));
         end else begin
            write_voxel(ADDR_W'($urandom), VOXEL_BITS'($urandom));
         end
      end

      drain_and_settle();
      if (pred.expected_samples.size() != 0)
         pred.report($sformatf("%0d samples never returned", pred.expected_samples.size()));
      if (pred.mismatch_count == 0) begin
         $display("trilinear_sample_mirror_boundary_top verification clean");
      end else begin
         $display("trilinear_sample_mirror_boundary_top verification failed");
      end
      $finish;
   end

endmodule
